[rtl/acrb_pkg.sv]
// Shared types and constants for the A-law capture ring buffer.
package acrb_pkg;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 13;
    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_ALAW_MODE   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUFFER_SIZE = 8'd1;

    localparam logic [7:0] ALAW_XOR = 8'hD5;
    localparam logic [3:0] ALAW_MANT_MASK = 4'hF;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PUSH2,
        BK_READ
    } t_back_state;

    // One classified operation handed from the front end to the back end.
    typedef struct packed {
        t_cmd               op;
        logic [7:0]         b0;
        logic [7:0]         b1;
        logic               two;
        logic [COUNT_W-1:0] count;
    } t_op;

    // One result transaction waiting for the output port.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } t_res;

endpackage

[rtl/acrb_front.sv]
// Front end: accepts commands, encodes samples in A-law mode and clamps read counts.
module acrb_front #(
    parameter int MAX_READ = 64
) (
    input  logic                           i_tvalid,
    output logic                           o_tready,
    input  logic [acrb_pkg::IN_DATA_W-1:0] i_tdata,
    input  logic [acrb_pkg::IN_USER_W-1:0] i_tuser,
    input  logic                           i_alaw_mode,
    input  logic                           i_q_full,
    output logic                           o_push,
    output acrb_pkg::t_op                  o_op
);

    function automatic logic [7:0] alaw_encode(input logic [15:0] raw);
        logic        sgn;
        logic [14:0] mag;
        logic [15:0] neg;
        logic [2:0]  seg;
        logic [3:0]  mant;
        sgn = raw[15];
        neg = ~raw + 16'd1;
        if (!sgn) begin
            mag = raw[14:0];
        end else if (raw == 16'h8000) begin
            mag = 15'h7FFF;
        end else begin
            mag = neg[14:0];
        end
        priority if (mag[14]) seg = 3'd7;
        else if (mag[13]) seg = 3'd6;
        else if (mag[12]) seg = 3'd5;
        else if (mag[11]) seg = 3'd4;
        else if (mag[10]) seg = 3'd3;
        else if (mag[9])  seg = 3'd2;
        else if (mag[8])  seg = 3'd1;
        else              seg = 3'd0;
        // Segment zero keeps the same step size as segment one.
        unique case (seg)
            3'd0:    mant = mag[7:4];
            3'd1:    mant = mag[7:4];
            3'd2:    mant = mag[8:5];
            3'd3:    mant = mag[9:6];
            3'd4:    mant = mag[10:7];
            3'd5:    mant = mag[11:8];
            3'd6:    mant = mag[12:9];
            default: mant = mag[13:10];
        endcase
        mant = mant & acrb_pkg::ALAW_MANT_MASK;
        return {sgn, seg, mant} ^ acrb_pkg::ALAW_XOR;
    endfunction

    logic [15:0]                    sample;
    logic [acrb_pkg::COUNT_W-1:0]   raw_count;
    acrb_pkg::t_cmd                 cmd;

    assign sample    = i_tdata[15:0];
    assign raw_count = i_tdata[22:16];
    assign cmd       = acrb_pkg::t_cmd'(i_tuser);
    assign o_tready  = ~i_q_full;
    // The unused command code is consumed without queuing anything.
    assign o_push    = i_tvalid && !i_q_full && (cmd != acrb_pkg::CMD_NONE);

    always_comb begin
        o_op.op    = cmd;
        o_op.two   = ~i_alaw_mode;
        o_op.b1    = sample[15:8];
        o_op.b0    = i_alaw_mode ? alaw_encode(sample) : sample[7:0];
        if (raw_count == '0) begin
            o_op.count = acrb_pkg::COUNT_W'(1);
        end else if (raw_count > acrb_pkg::COUNT_W'(MAX_READ)) begin
            o_op.count = acrb_pkg::COUNT_W'(MAX_READ);
        end else begin
            o_op.count = raw_count;
        end
    end

endmodule

[rtl/acrb_queue.sv]
// Two-entry operation queue between the front end and the back end.
module acrb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  acrb_pkg::t_op i_data,
    output logic          o_full,
    output logic          o_valid,
    output acrb_pkg::t_op o_data,
    input  logic          i_pop
);

    localparam int AW = $clog2(acrb_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(acrb_pkg::QUEUE_DEPTH + 1);

    acrb_pkg::t_op r_slot [acrb_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(acrb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = do_push ? r_wr + AW'(1) : r_wr;
        n_rd  = do_pop ? r_rd + AW'(1) : r_rd;
        n_cnt = r_cnt + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

[rtl/acrb_back.sv]
// Back end: ring memory, pointers, read sequencer and output queue.
module acrb_back #(
    parameter int RING_DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [$clog2(RING_DEPTH + 1)-1:0]     i_size,
    input  logic                                  i_clear,
    input  logic                                  i_op_valid,
    input  acrb_pkg::t_op                         i_op,
    output logic                                  o_op_pop,
    output logic                                  o_res_valid,
    output acrb_pkg::t_res                        o_res,
    input  logic                                  i_res_ready
);

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int MW = (FW > acrb_pkg::COUNT_W) ? FW : acrb_pkg::COUNT_W;
    localparam int CNTW = acrb_pkg::COUNT_W;

    acrb_pkg::t_back_state r_state, n_state;

    logic [7:0]      r_ring [RING_DEPTH];
    logic [7:0]      r_rd_data;
    logic [PW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_rp, n_rp;
    logic [FW-1:0]   r_fill, n_fill;
    logic [CNTW-1:0] r_left, n_left;
    logic            r_rd_empty, n_rd_empty;
    logic [7:0]      r_b1, n_b1;
    logic            r_pend, r_pend_last, r_pend_empty;

    acrb_pkg::t_res  r_oq [2];
    logic            r_oh, r_ot;
    logic [1:0]      r_ocnt;

    logic            q_pop;
    logic            out_pop;
    logic [2:0]      occ;
    logic            slot;
    logic            issue;
    logic            wr_en;
    logic [7:0]      wr_byte;
    logic [PW-1:0]   wp_inc;
    logic [PW-1:0]   rp_inc;
    logic [FW-1:0]   wp_sum;
    logic [FW-1:0]   rp_sum;
    logic [MW-1:0]   nsel;

    assign o_res_valid = (r_ocnt != 2'd0);
    assign o_res       = r_oq[r_oh];
    assign out_pop     = o_res_valid && i_res_ready;
    assign occ         = {1'b0, r_ocnt} + {2'b00, r_pend};
    // Counting the byte in flight from the memory keeps the output queue from overflowing.
    assign slot        = (occ < 3'd2) || ((occ == 3'd2) && out_pop);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            acrb_pkg::BK_IDLE: begin
                if (i_op_valid) begin
                    if (i_op.op == acrb_pkg::CMD_PUSH && i_op.two) begin
                        n_state = acrb_pkg::BK_PUSH2;
                    end else if (i_op.op == acrb_pkg::CMD_READ) begin
                        n_state = acrb_pkg::BK_READ;
                    end
                end
            end
            acrb_pkg::BK_PUSH2: n_state = acrb_pkg::BK_IDLE;
            acrb_pkg::BK_READ: begin
                if (slot && r_left == CNTW'(1)) begin
                    n_state = acrb_pkg::BK_IDLE;
                end
            end
            default: n_state = acrb_pkg::BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        q_pop   = 1'b0;
        issue   = 1'b0;
        wr_en   = 1'b0;
        wr_byte = i_op.b0;
        unique case (r_state)
            acrb_pkg::BK_IDLE: begin
                q_pop = i_op_valid;
                wr_en = i_op_valid && (i_op.op == acrb_pkg::CMD_PUSH);
            end
            acrb_pkg::BK_PUSH2: begin
                wr_en   = 1'b1;
                wr_byte = r_b1;
            end
            acrb_pkg::BK_READ: issue = slot;
            default: ;
        endcase
    end

    assign o_op_pop = q_pop;

    always_comb begin
        wp_sum = FW'(r_wp) + FW'(1);
        rp_sum = FW'(r_rp) + FW'(1);
        wp_inc = (wp_sum == i_size) ? '0 : r_wp + PW'(1);
        rp_inc = (rp_sum == i_size) ? '0 : r_rp + PW'(1);
        nsel   = (MW'(i_op.count) < MW'(r_fill)) ? MW'(i_op.count) : MW'(r_fill);
    end

    // Pointer and count updates.
    always_comb begin
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_fill     = r_fill;
        n_left     = r_left;
        n_rd_empty = r_rd_empty;
        n_b1       = r_b1;
        if (i_clear) begin
            n_wp   = '0;
            n_rp   = '0;
            n_fill = '0;
        end else begin
            if (wr_en) begin
                n_wp = wp_inc;
                // A full ring drops its oldest byte.
                if (r_fill < i_size) begin
                    n_fill = r_fill + FW'(1);
                end else begin
                    n_rp = wp_inc;
                end
            end
            if (q_pop) begin
                unique case (i_op.op)
                    acrb_pkg::CMD_PUSH: n_b1 = i_op.b1;
                    acrb_pkg::CMD_CLEAR: begin
                        n_wp   = '0;
                        n_rp   = '0;
                        n_fill = '0;
                    end
                    acrb_pkg::CMD_READ: begin
                        if (r_fill == '0) begin
                            n_rd_empty = 1'b1;
                            n_left     = CNTW'(1);
                        end else begin
                            n_rd_empty = 1'b0;
                            n_left     = CNTW'(nsel);
                            n_fill     = r_fill - FW'(nsel);
                        end
                    end
                    default: ;
                endcase
            end
            if (issue) begin
                n_left = r_left - CNTW'(1);
                if (!r_rd_empty) begin
                    n_rp = rp_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= acrb_pkg::BK_IDLE;
            r_wp       <= '0;
            r_rp       <= '0;
            r_fill     <= '0;
            r_left     <= '0;
            r_rd_empty <= 1'b0;
            r_pend     <= 1'b0;
            r_oh       <= 1'b0;
            r_ot       <= 1'b0;
            r_ocnt     <= 2'd0;
        end else begin
            r_state    <= n_state;
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_fill     <= n_fill;
            r_left     <= n_left;
            r_rd_empty <= n_rd_empty;
            r_pend     <= issue;
            r_oh       <= out_pop ? ~r_oh : r_oh;
            r_ot       <= r_pend ? ~r_ot : r_ot;
            r_ocnt     <= r_ocnt + {1'b0, r_pend} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1         <= n_b1;
        r_pend_last  <= (r_left == CNTW'(1));
        r_pend_empty <= r_rd_empty;
        if (r_pend) begin
            r_oq[r_ot].data  <= r_pend_empty ? 8'h00 : r_rd_data;
            r_oq[r_ot].last  <= r_pend_last;
            r_oq[r_ot].empty <= r_pend_empty;
        end
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[r_wp] <= wr_byte;
        end
        if (issue) begin
            r_rd_data <= r_ring[r_rp];
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= i_size)
        else $error("fill count exceeds active ring size");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FW'(r_wp) < i_size) && (FW'(r_rp) < i_size))
        else $error("ring pointer outside active size");

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ <= 3'd2)
        else $error("output queue and read in flight exceed its depth");

    a_push2_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == acrb_pkg::BK_PUSH2) |-> ($past(wr_en) && !q_pop))
        else $error("second raw byte not preceded by the first");

endmodule

[rtl/alaw_capture_ring_buffer.sv]
// Top level of the A-law capture ring buffer.
//
// Commands enter on the s_ stream: s_tuser is the command (push, read, clear),
// s_tdata carries the sample and the read count. Read results leave on the
// m_ stream one byte per transaction, oldest first, with m_tlast on the final
// byte of a read and m_tuser flagging a read of an empty ring.
// Registers are written through i_cfg_we/i_cfg_addr/i_cfg_wdata; the user must do so only while idle,
// which the block itself does not enforce. Writing the buffer size also empties the ring.
// A command passes a two-entry queue into the back end. An A-law push writes
// one byte to the ring, a raw push two in turn, since the ring memory has one write port.
// A read streams one byte per cycle while m_tready is high; the first byte
// passes the command queue, the read state, the memory read register and the
// output queue, and a read holds the back end until its last byte is issued.
// When the receiver stalls, a two-entry output queue holds results, the read
// stops issuing memory reads, and the command queue fills so s_tready drops.
// Reset empties the ring, sets A-law mode and a buffer size of RING_DEPTH capped at 4096.
// The ring memory is not cleared; only written bytes are ever read.
module alaw_capture_ring_buffer #(
    parameter int RING_DEPTH = 4096,
    parameter int MAX_READ   = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [acrb_pkg::IN_DATA_W-1:0]        s_tdata,   // sample[15:0], read_count[22:16]
    input  logic [acrb_pkg::IN_USER_W-1:0]        s_tuser,   // command[1:0]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [acrb_pkg::OUT_DATA_W-1:0]       m_tdata,   // read_data[7:0]
    output logic                                  m_tlast,
    output logic [0:0]                            m_tuser,   // empty_res[0]
    input  logic                                  i_cfg_we,
    input  logic [acrb_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [acrb_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    localparam int FW   = $clog2(RING_DEPTH + 1);
    localparam int CMPW = (FW > acrb_pkg::CFG_DATA_W) ? FW : acrb_pkg::CFG_DATA_W;
    localparam int RESET_SIZE = (RING_DEPTH < 4096) ? RING_DEPTH : 4096;

    logic             r_alaw_mode;
    logic [FW-1:0]    r_size;
    logic [FW-1:0]    n_size;
    logic [CMPW-1:0]  size_wide;
    logic             size_wr;

    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    acrb_pkg::t_op    front_op;
    acrb_pkg::t_op    head_op;
    acrb_pkg::t_res   res;

    assign size_wr   = i_cfg_we && (i_cfg_addr == acrb_pkg::CFG_BUFFER_SIZE);
    assign size_wide = CMPW'(i_cfg_wdata);

    always_comb begin
        if (size_wide < CMPW'(2)) begin
            n_size = FW'(2);
        end else if (size_wide > CMPW'(RING_DEPTH)) begin
            n_size = FW'(RING_DEPTH);
        end else begin
            n_size = FW'(size_wide);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alaw_mode <= 1'b1;
            r_size      <= FW'(RESET_SIZE);
        end else if (i_cfg_we) begin
            if (i_cfg_addr == acrb_pkg::CFG_ALAW_MODE) begin
                r_alaw_mode <= i_cfg_wdata[0];
            end
            if (size_wr) begin
                r_size <= n_size;
            end
        end
    end

    acrb_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .i_tvalid    (s_tvalid),
        .o_tready    (s_tready),
        .i_tdata     (s_tdata),
        .i_tuser     (s_tuser),
        .i_alaw_mode (r_alaw_mode),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_op        (front_op)
    );

    acrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_op),
        .i_pop   (q_pop)
    );

    acrb_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (r_size),
        .i_clear     (size_wr),
        .i_op_valid  (q_valid),
        .i_op        (head_op),
        .o_op_pop    (q_pop),
        .o_res_valid (m_tvalid),
        .o_res       (res),
        .i_res_ready (m_tready)
    );

    assign m_tdata    = res.data;
    assign m_tlast    = res.last;
    assign m_tuser[0] = res.empty;

endmodule
